// ===== rtl/bpts_pkg.sv =====
// shared types and constants for the bitmap priority thread scheduler
package bpts_pkg;

    localparam int PRIORITY_LEVELS = 32;
    localparam int MAX_THREADS     = 16;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_SCHEDULE = 3'd2,
        OP_ENTER    = 3'd3,
        OP_EXIT     = 3'd4,
        OP_START    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_READY = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] thread_id;
        logic [4:0] priority_req;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic        switched;
        logic        from_valid;
        logic [3:0]  old_tid;
        logic [3:0]  new_tid;
        logic [4:0]  running_priority;
        logic [7:0]  lock_level;
        logic [31:0] ready_levels;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic exec;
    } t_ctl_cmd;

endpackage

// ===== rtl/bitmap_priority_thread_scheduler.sv =====
// top level of the bitmap priority thread scheduler
// Usage: one input channel (i_in_valid / o_in_stall, payload i_in_beat) carries a
// kernel call: insert, remove, schedule, enter or exit critical, start. One output
// channel (o_out_valid / i_out_stall, payload o_out_beat) returns exactly one beat
// per call with status, switch report, running level, lock depth and the bitmap.
// Calls do not overlap: the next call is taken the cycle after the result beat
// leaves. The sequencer steps through capture, link and head read, update and
// deliver.
// The priority encode over the ready bitmap and the link reads share one cycle.
// Reset (i_rst_n low, synchronous) empties all levels, clears lock depth, marks
// the scheduler not started and sets the running level to 31. Link tables are
// only read where the bitmap or ready flags mark them written.
// While the receiver stalls, the result holds and no new call is accepted.
module bitmap_priority_thread_scheduler
    import bpts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);
    t_ctl_cmd w_cmd;

    bpts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    bpts_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_beat  (i_in_beat),
        .o_beat  (o_out_beat)
    );
endmodule

// ===== rtl/bpts_datapath.sv =====
// link storage, bitmap, current thread and result register
module bpts_datapath
    import bpts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_in_beat  i_beat,
    output t_out_beat o_beat
);
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    logic [2:0] r_op;
    logic [3:0] r_tid;
    logic [4:0] r_lv;

    logic [3:0] r_head [PRIORITY_LEVELS];
    logic [3:0] r_tail [PRIORITY_LEVELS];
    logic [3:0] r_next [MAX_THREADS];
    logic [3:0] r_prev [MAX_THREADS];
    logic [LW-1:0] r_tlev [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_rdy;
    logic [PRIORITY_LEVELS-1:0] r_bmp;
    logic [3:0] r_cur;
    logic       r_pres;
    logic [4:0] r_cur_lv;
    logic [7:0] r_lock;

    // values sampled in the read cycle
    logic [3:0] r_h, r_t, r_nx, r_pv, r_win_head;
    logic       r_tr, r_lvmatch, r_bit, r_any;
    logic [4:0] r_win;
    logic       r_inrange;

    logic [LW-1:0] w_lv;
    logic [TW-1:0] w_t;
    logic          w_any;
    logic [4:0]    w_win;

    assign w_lv = r_lv[LW-1:0];
    assign w_t  = r_tid[TW-1:0];

    // lowest set bit of the bitmap
    always_comb begin
        w_any = 1'b0;
        w_win = 5'd0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (r_bmp[i] && i < 32) begin
                w_any = 1'b1;
                w_win = 5'(i);
            end
        end
    end

    t_out_beat n_out;
    logic [7:0] w_lock_dn;
    logic       w_sched, w_sw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_beat.operation;
            r_tid <= i_beat.thread_id;
            r_lv  <= i_beat.priority_req;
        end
        if (i_cmd.read) begin
            r_inrange  <= (32'(r_tid) < MAX_THREADS) && (32'(r_lv) < PRIORITY_LEVELS);
            r_h        <= r_head[w_lv];
            r_t        <= r_tail[w_lv];
            r_nx       <= r_next[w_t];
            r_pv       <= r_prev[w_t];
            r_tr       <= r_rdy[w_t];
            r_lvmatch  <= (r_tlev[w_t] == w_lv);
            r_bit      <= r_bmp[w_lv];
            r_any      <= w_any;
            r_win      <= w_win;
            r_win_head <= r_head[w_win[LW-1:0]];
        end
    end

    always_comb begin
        w_lock_dn = (r_lock != 8'd0) ? r_lock - 8'd1 : 8'd0;
        w_sched = (r_op == OP_SCHEDULE) ||
                  (r_op == OP_EXIT && w_lock_dn == 8'd0 && r_pres);
        w_sw = r_any && ((r_op == OP_SCHEDULE) ? (r_lock == 8'd0) : 1'b1)
               && !(r_pres && r_cur == r_win_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy    <= '0;
            r_bmp    <= '0;
            r_cur    <= '0;
            r_pres   <= 1'b0;
            r_cur_lv <= 5'd31;
            r_lock   <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_INSERT: if (r_inrange && !r_tr) begin
                    if (r_bit) begin
                        r_next[r_t[TW-1:0]] <= r_tid;
                        r_prev[w_t] <= r_t;
                    end else begin
                        r_head[w_lv] <= r_tid;
                        r_prev[w_t]  <= r_tid;
                    end
                    r_next[w_t]  <= r_tid;
                    r_tail[w_lv] <= r_tid;
                    r_rdy[w_t]   <= 1'b1;
                    r_tlev[w_t]  <= w_lv;
                    r_bmp[w_lv]  <= 1'b1;
                end
                OP_REMOVE: if (r_inrange && r_tr && r_lvmatch) begin
                    if (r_h == r_tid && r_t == r_tid) begin
                        r_bmp[w_lv] <= 1'b0;
                    end else begin
                        if (r_h == r_tid) r_head[w_lv] <= r_nx;
                        else r_next[r_pv[TW-1:0]] <= r_nx;
                        if (r_t == r_tid) r_tail[w_lv] <= r_pv;
                        else r_prev[r_nx[TW-1:0]] <= r_pv;
                    end
                    r_rdy[w_t] <= 1'b0;
                end
                OP_ENTER: if (r_lock != LOCK_MAX) r_lock <= r_lock + 8'd1;
                OP_EXIT:  r_lock <= w_lock_dn;
                default: ;
            endcase
            if ((w_sched && w_sw) || (r_op == OP_START && r_any)) begin
                r_cur    <= r_win_head;
                r_pres   <= 1'b1;
                r_cur_lv <= r_win;
            end
        end
    end

    always_comb begin
        n_out = '0;
        n_out.status = ST_OK;
        unique case (r_op)
            OP_INSERT: if (!r_inrange || r_tr) n_out.status = ST_INVALID;
            OP_REMOVE: if (!r_inrange || !r_tr || !r_lvmatch) n_out.status = ST_INVALID;
            OP_START: begin
                if (!r_any) n_out.status = ST_NO_READY;
                else begin
                    n_out.switched = 1'b1;
                    n_out.new_tid  = r_win_head;
                end
            end
            default: ;
        endcase
        if (w_sched) begin
            if (!r_any) n_out.status = ST_NO_READY;
            else if (w_sw) begin
                n_out.switched   = 1'b1;
                n_out.from_valid = r_pres;
                n_out.old_tid    = r_pres ? r_cur : 4'd0;
                n_out.new_tid    = r_win_head;
            end
        end
    end

    t_out_beat r_res;
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_res <= n_out;
    end

    always_comb begin
        o_beat = r_res;
        o_beat.running_priority = r_cur_lv;
        o_beat.lock_level       = r_lock;
        o_beat.ready_levels     = 32'(r_bmp);
    end
endmodule

// ===== rtl/bpts_ctrl.sv =====
// sequencer for one operation: capture, read, execute, deliver
module bpts_ctrl
    import bpts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ctl_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/bpts_checker.sv =====
// port-level checks for the scheduler, bound to the top level
module bpts_checker
    import bpts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed under stall");

    // no new call while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // accepted call yields a result after the read and execute states
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##2 o_out_valid)
        else $error("result missing");

    // a switch always names a valid status
    a_sw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.switched |-> o_out_beat.status == ST_OK)
        else $error("switch with bad status");
endmodule

bind bitmap_priority_thread_scheduler bpts_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ===== tb/tb_bitmap_priority_thread_scheduler.sv =====
// self-checking testbench for the bitmap priority thread scheduler
module tb_bitmap_priority_thread_scheduler;
    import bpts_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_beat;

    bitmap_priority_thread_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    // scheduler shadow state
    logic [31:0] sh_bitmap;
    logic [3:0]  sh_head [32];
    logic [3:0]  sh_tail [32];
    logic [3:0]  sh_next [16];
    logic [3:0]  sh_prev [16];
    logic        sh_ready [16];
    logic [4:0]  sh_tlevel [16];
    logic [3:0]  sh_cur;
    logic        sh_started;
    logic [4:0]  sh_cur_level;
    logic [7:0]  sh_lock;

    t_in_beat  call_queue [$];
    t_out_beat result_queue [$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        mismatches;
    int        results_seen;
    int        cycles;
    logic      stim_done;

    function automatic logic top_level(output logic [4:0] lv);
        for (int i = 0; i < 32; i++) begin
            if (sh_bitmap[i]) begin
                lv = 5'(i);
                return 1'b1;
            end
        end
        lv = '0;
        return 1'b0;
    endfunction

    function automatic void try_switch(inout t_out_beat r);
        logic [4:0] lv;
        logic [3:0] to;
        if (!top_level(lv)) begin
            r.status = ST_NO_READY;
            return;
        end
        to = sh_head[lv];
        if (sh_lock == 0 && !(sh_started && sh_cur == to)) begin
            r.switched    = 1'b1;
            r.from_valid  = sh_started;
            r.old_tid     = sh_started ? sh_cur : 4'd0;
            r.new_tid     = to;
            sh_cur        = to;
            sh_started    = 1'b1;
            sh_cur_level  = lv;
        end
    endfunction

    function automatic t_out_beat predict_call(t_in_beat c);
        t_out_beat  r;
        logic [3:0] t, nx, pv;
        logic [4:0] lv;
        logic       hd, tl;
        r  = '0;
        t  = c.thread_id;
        lv = c.priority_req;
        case (c.operation)
            OP_INSERT: begin
                if (sh_ready[t]) begin
                    r.status = ST_INVALID;
                end else begin
                    if (sh_bitmap[lv]) begin
                        sh_next[sh_tail[lv]] = t;
                        sh_prev[t] = sh_tail[lv];
                    end else begin
                        sh_head[lv] = t;
                        sh_prev[t] = t;
                    end
                    sh_next[t]    = t;
                    sh_tail[lv]   = t;
                    sh_ready[t]   = 1'b1;
                    sh_tlevel[t]  = lv;
                    sh_bitmap[lv] = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!sh_ready[t] || sh_tlevel[t] != lv) begin
                    r.status = ST_INVALID;
                end else begin
                    hd = sh_head[lv] == t;
                    tl = sh_tail[lv] == t;
                    nx = sh_next[t];
                    pv = sh_prev[t];
                    if (hd && tl) begin
                        sh_bitmap[lv] = 1'b0;
                    end else begin
                        if (hd) sh_head[lv] = nx; else sh_next[pv] = nx;
                        if (tl) sh_tail[lv] = pv; else sh_prev[nx] = pv;
                    end
                    sh_ready[t] = 1'b0;
                end
            end
            OP_SCHEDULE: try_switch(r);
            OP_ENTER: begin
                if (sh_lock != LOCK_MAX) sh_lock++;
            end
            OP_EXIT: begin
                if (sh_lock != 0) sh_lock--;
                if (sh_lock == 0 && sh_started) try_switch(r);
            end
            OP_START: begin
                if (!top_level(lv)) begin
                    r.status = ST_NO_READY;
                end else begin
                    sh_cur       = sh_head[lv];
                    sh_started   = 1'b1;
                    sh_cur_level = lv;
                    r.switched   = 1'b1;
                    r.new_tid    = sh_cur;
                end
            end
            default: ;
        endcase
        r.running_priority = sh_cur_level;
        r.lock_level       = sh_lock;
        r.ready_levels     = sh_bitmap;
        return r;
    endfunction

    function automatic t_in_beat mk_call(logic [2:0] op, logic [3:0] t, logic [4:0] lv);
        t_in_beat c;
        c.operation    = op;
        c.thread_id    = t;
        c.priority_req = lv;
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver: present next call at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (!(i_in_valid && o_in_stall)) begin
                if (call_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_beat  <= call_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // predict at acceptance, check at delivery
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && !o_in_stall)
            result_queue.push_back(predict_call(i_in_beat));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (result_queue.size() == 0) begin
                if (mismatches < 10) $display("unexpected result beat %p", o_out_beat);
                mismatches <= mismatches + 1;
            end else if (result_queue[0] !== o_out_beat) begin
                if (mismatches < 10)
                    $display("result mismatch: expected %p actual %p",
                             result_queue[0], o_out_beat);
                mismatches <= mismatches + 1;
                void'(result_queue.pop_front());
            end else begin
                void'(result_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("timeout with %0d results outstanding", result_queue.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 40)
                call_queue.push_back(mk_call(OP_INSERT, 4'($urandom),
                                             k < 30 ? 5'($urandom_range(3)) : 5'($urandom)));
            else if (k < 65)
                call_queue.push_back(mk_call(OP_REMOVE, 4'($urandom),
                                             k < 60 ? 5'($urandom_range(3)) : 5'($urandom)));
            else if (k < 78)
                call_queue.push_back(mk_call(OP_SCHEDULE, 4'($urandom), 5'($urandom)));
            else if (k < 86)
                call_queue.push_back(mk_call(OP_ENTER, 4'($urandom), 5'($urandom)));
            else if (k < 94)
                call_queue.push_back(mk_call(OP_EXIT, 4'($urandom), 5'($urandom)));
            else if (k < 98)
                call_queue.push_back(mk_call(OP_START, 4'($urandom), 5'($urandom)));
            else
                call_queue.push_back(mk_call(3'($urandom_range(7, 6)), 4'($urandom),
                                             5'($urandom)));
        end
    endtask

    task automatic run_phase(int s_pct, int r_pct, int n);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        queue_random(n);
        wait (call_queue.size() == 0 && !i_in_valid && result_queue.size() == 0);
    endtask

    initial begin
        sh_bitmap = '0; sh_cur = '0; sh_started = 1'b0; sh_cur_level = 5'd31; sh_lock = '0;
        for (int i = 0; i < 32; i++) begin
            sh_head[i] = '0;
            sh_tail[i] = '0;
        end
        for (int i = 0; i < 16; i++) begin
            sh_next[i] = '0; sh_prev[i] = '0; sh_ready[i] = 1'b0; sh_tlevel[i] = '0;
        end
        mismatches = 0; results_seen = 0; cycles = 0;
        send_idle_pct = 9; recv_idle_pct = 74;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0; i_in_beat = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: empty schedule and start, field extremes, locking, odd codes
        call_queue.push_back(mk_call(OP_SCHEDULE, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_START, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_REMOVE, 4'd3, 5'd3));
        call_queue.push_back(mk_call(OP_INSERT, 4'd15, 5'd31));
        call_queue.push_back(mk_call(OP_INSERT, 4'd15, 5'd31));
        call_queue.push_back(mk_call(OP_SCHEDULE, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_INSERT, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_INSERT, 4'd5, 5'd0));
        call_queue.push_back(mk_call(OP_INSERT, 4'd10, 5'd0));
        call_queue.push_back(mk_call(OP_ENTER, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_SCHEDULE, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_EXIT, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_EXIT, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_REMOVE, 4'd5, 5'd1));
        call_queue.push_back(mk_call(OP_REMOVE, 4'd5, 5'd0));
        call_queue.push_back(mk_call(OP_REMOVE, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_SCHEDULE, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_START, 4'd0, 5'd0));
        call_queue.push_back(mk_call(3'd6, 4'd0, 5'd0));
        call_queue.push_back(mk_call(3'd7, 4'd15, 5'd31));
        // saturate the lock depth, then unwind it back to zero
        for (int i = 0; i < 257; i++) call_queue.push_back(mk_call(OP_ENTER, 4'd0, 5'd0));
        call_queue.push_back(mk_call(OP_EXIT, 4'd0, 5'd0));
        for (int i = 0; i < 255; i++) call_queue.push_back(mk_call(OP_EXIT, 4'd0, 5'd0));

        run_phase(9, 74, 420);
        run_phase(74, 9, 420);
        run_phase(0, 0, 420);
        repeat (20) @(posedge i_clk);

        $display("ran directed and random kernel calls over three idling phases;");
        $display("%0d result beats checked, final bitmap %h", results_seen, sh_bitmap);
        if (mismatches == 0 && result_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
